[rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module under rtl/.
package utf8d_pkg;

    localparam int CP_W  = 21;   // code point width
    localparam int CNT_W = 3;    // results per input byte, 0 to 4

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Lead and continuation byte classes
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Continuations still needed by a freshly opened sequence
    localparam logic [1:0] EXP_NONE = 2'd0;
    localparam logic [1:0] EXP_ONE  = 2'd1;
    localparam logic [1:0] EXP_TWO  = 2'd2;
    localparam logic [1:0] EXP_THREE = 2'd3;

    // Results caused by one input byte: cnt-1 replacements, then the final one
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CP_W-1:0]  cp_last;
        logic             err_last;
        logic             text_end;
    } burst_t;

endpackage

[rtl/utf8d_decode.sv]
// Sequence state and per-byte decode for the UTF-8 stream decoder.
// Depends on utf8d_pkg; instantiated by utf8_stream_decoder.
module utf8d_decode import utf8d_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      item_byte,
    input  logic            item_end,
    input  logic            commit,     // byte leaves the input register
    output burst_t          desc
);

    logic [CP_W-1:0] pv_reg, pv_next;
    logic [1:0]      exp_reg, exp_next;
    logic [1:0]      seen_reg, seen_next;

    logic            fresh_emit;
    logic [CP_W-1:0] fresh_cp;
    logic            fresh_err;
    logic [1:0]      fresh_exp;
    logic [CP_W-1:0] fresh_pv;

    logic            is_cont;
    logic [1:0]      seen_inc;
    logic [CP_W-1:0] pv_acc;
    logic [CNT_W-1:0] flush_cnt;

    // Classify the byte as if no sequence were open
    always_comb begin
        fresh_emit = 1'b0;
        fresh_cp   = REPLACEMENT_CP;
        fresh_err  = 1'b1;
        fresh_exp  = EXP_NONE;
        fresh_pv   = '0;
        if (!item_byte[7]) begin
            fresh_emit = 1'b1;
            fresh_cp   = {{(CP_W-8){1'b0}}, item_byte};
            fresh_err  = 1'b0;
        end else if (item_byte[7:5] == LEAD2_TAG) begin
            fresh_exp = EXP_ONE;
            fresh_pv  = {{(CP_W-5){1'b0}}, item_byte[4:0]};
        end else if (item_byte[7:4] == LEAD3_TAG) begin
            fresh_exp = EXP_TWO;
            fresh_pv  = {{(CP_W-4){1'b0}}, item_byte[3:0]};
        end else if (item_byte[7:3] == LEAD4_TAG) begin
            fresh_exp = EXP_THREE;
            fresh_pv  = {{(CP_W-3){1'b0}}, item_byte[2:0]};
        end else begin
            // stray continuation or 0xF8 to 0xFF
            fresh_emit = 1'b1;
        end
    end

    assign is_cont   = (item_byte[7:6] == CONT_TAG);
    assign seen_inc  = seen_reg + 2'd1;
    assign pv_acc    = {pv_reg[CP_W-7:0], item_byte[5:0]};
    assign flush_cnt = {1'b0, seen_reg} + 3'd1;

    // Work out the results of this byte and the state it leaves
    always_comb begin
        pv_next       = pv_reg;
        exp_next      = exp_reg;
        seen_next     = seen_reg;
        desc.cnt      = '0;
        desc.cp_last  = REPLACEMENT_CP;
        desc.err_last = 1'b1;
        desc.text_end = item_end;
        if (exp_reg != EXP_NONE && is_cont) begin
            // extend the open sequence
            if (seen_inc >= exp_reg) begin
                desc.cnt      = 3'd1;
                desc.cp_last  = pv_acc;
                desc.err_last = 1'b0;
                pv_next       = '0;
                exp_next      = EXP_NONE;
                seen_next     = 2'd0;
            end else if (item_end) begin
                desc.cnt  = {1'b0, seen_inc} + 3'd1;
                pv_next   = '0;
                exp_next  = EXP_NONE;
                seen_next = 2'd0;
            end else begin
                pv_next   = pv_acc;
                seen_next = seen_inc;
            end
        end else begin
            // replace any broken sequence, then decode the byte fresh
            if (fresh_emit) begin
                desc.cnt      = (exp_reg != EXP_NONE) ? flush_cnt + 3'd1 : 3'd1;
                desc.cp_last  = fresh_cp;
                desc.err_last = fresh_err;
                pv_next       = '0;
                exp_next      = EXP_NONE;
                seen_next     = 2'd0;
            end else if (item_end) begin
                desc.cnt  = (exp_reg != EXP_NONE) ? flush_cnt + 3'd1 : 3'd1;
                pv_next   = '0;
                exp_next  = EXP_NONE;
                seen_next = 2'd0;
            end else begin
                desc.cnt  = (exp_reg != EXP_NONE) ? flush_cnt : 3'd0;
                pv_next   = fresh_pv;
                exp_next  = fresh_exp;
                seen_next = 2'd0;
            end
        end
    end

    // Hold sequence state until a byte is committed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg   <= '0;
            exp_reg  <= EXP_NONE;
            seen_reg <= 2'd0;
        end else if (commit) begin
            pv_reg   <= pv_next;
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_seen_below_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_reg != EXP_NONE |-> seen_reg < exp_reg)
        else $error("continuation count reached expected length");
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_reg == EXP_NONE |-> seen_reg == 2'd0 && pv_reg == '0)
        else $error("sequence state not cleared while idle");
    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && item_end |=> exp_reg == EXP_NONE)
        else $error("sequence left open after end of text");
`endif

endmodule

[rtl/utf8d_burst.sv]
// Result sequencer: plays out the results of one byte, one per transfer.
// Depends on utf8d_pkg; instantiated by utf8_stream_decoder.
module utf8d_burst import utf8d_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  burst_t          desc,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,    // [20:0] code_point, zero filled
    output logic [1:0]      m_tuser,    // [0] decode_error, [1] run_last
    output logic            m_tlast     // text_last
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CP_W-1:0]  cp_reg;
    logic             err_reg;
    logic             end_reg;
    logic             final_one;
    logic [CP_W-1:0]  out_cp;

    assign final_one = (cnt_reg == 3'd1);
    assign free      = (cnt_reg == '0) || (final_one && m_tready);

    // Count down the pending results; reload when empty or as the last one goes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= desc.cnt;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg  <= desc.cp_last;
            err_reg <= desc.err_last;
            end_reg <= desc.text_end;
        end
    end

    // Earlier results of a run are always replacements
    assign out_cp   = final_one ? cp_reg : REPLACEMENT_CP;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {3'b000, out_cp};
    assign m_tuser  = {final_one, final_one ? err_reg : 1'b1};
    assign m_tlast  = final_one && end_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result count out of range");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free && desc.cnt != '0)
        else $error("burst loaded while busy or empty");
    a_early_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tuser[0] && out_cp == REPLACEMENT_CP)
        else $error("non-final result is not a replacement");
    a_text_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tvalid && m_tuser[1])
        else $error("text end outside final result of a run");
`endif

endmodule

[rtl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: input register, decode, sequencer.
// Depends on utf8d_pkg, utf8d_decode and utf8d_burst.
//
//   channel  direction  tdata            tuser                      tlast
//   s_       in         [7:0] data_byte  -                          text_end
//   m_       out        [20:0] code_pt   [0] decode_error [1] run   text_last
//
// One byte is decoded per cycle while the sequencer can take its results; a
// byte gives one transfer per result (mostly one, up to four when a broken
// sequence is replaced). Bytes that cause no result leave with no transfer out.
// Reset is synchronous on aresetn low and clears the sequence state.
// A stalled output holds the byte in the input register; the input side
// stalls only once that register is also full.
module utf8_stream_decoder import utf8d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // text_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] code_point, rest zero
    output logic [1:0]  m_tuser,    // [0] decode_error, [1] run_last
    output logic        m_tlast     // text_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    burst_t     desc;
    logic       burst_free;
    logic       commit;
    logic       load;

    // Advance a byte once its results can be taken by the sequencer
    assign commit   = in_valid_reg && (desc.cnt == '0 || burst_free);
    assign load     = commit && desc.cnt != '0;
    assign s_tready = !in_valid_reg || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    utf8d_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_byte (in_byte_reg),
        .item_end  (in_end_reg),
        .commit    (commit),
        .desc      (desc)
    );

    utf8d_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .desc     (desc),
        .free     (burst_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for utf8_stream_decoder: drives text bytes with random gaps and
// checks every code point against a predictor of the decoder kept in this file.
// Depends on utf8d_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;
    import utf8d_pkg::*;

    localparam int TOTAL_BYTES = 370;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES = 300;

    // One decoded result as it should leave the m_ channel
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            err;
        logic            run_last;
        logic            text_last;
    } cp_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Text bytes still to be offered, {text_end, data_byte}
    logic [8:0]  pending_bytes[$];
    cp_result_t  expected_cps[$];

    // Predictor sequence state
    logic [CP_W-1:0] partial_cp = '0;
    logic [1:0]      conts_needed = EXP_NONE;
    logic [1:0]      conts_seen = 2'd0;
    cp_result_t      burst[4];
    int              burst_n;

    int   error_cnt = 0;
    int   bytes_sent = 0;
    int   results_seen = 0;
    bit   offering = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Append one result to the burst caused by the current byte
    task automatic add_cp(input logic [CP_W-1:0] cp, input logic err);
        cp_result_t r;
        r.cp = cp;
        r.err = err;
        r.run_last = 1'b0;
        r.text_last = 1'b0;
        burst[burst_n] = r;
        burst_n++;
    endtask

    // Replace an open sequence: one replacement for the lead, one per continuation
    task automatic flush_sequence();
        add_cp(REPLACEMENT_CP, 1'b1);
        for (int i = 0; i < conts_seen; i++)
            add_cp(REPLACEMENT_CP, 1'b1);
        partial_cp = '0;
        conts_needed = EXP_NONE;
        conts_seen = 2'd0;
    endtask

    // Decode a byte with no sequence open
    task automatic start_byte(input logic [7:0] b);
        if (!b[7]) begin
            add_cp({13'd0, b}, 1'b0);
        end else if (b[7:5] == LEAD2_TAG) begin
            partial_cp = {16'd0, b[4:0]};
            conts_needed = EXP_ONE;
            conts_seen = 2'd0;
        end else if (b[7:4] == LEAD3_TAG) begin
            partial_cp = {17'd0, b[3:0]};
            conts_needed = EXP_TWO;
            conts_seen = 2'd0;
        end else if (b[7:3] == LEAD4_TAG) begin
            partial_cp = {18'd0, b[2:0]};
            conts_needed = EXP_THREE;
            conts_seen = 2'd0;
        end else begin
            add_cp(REPLACEMENT_CP, 1'b1);
        end
    endtask

    // Predict the results of one accepted byte and queue them
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        cp_result_t r;
        burst_n = 0;
        if (conts_needed != EXP_NONE) begin
            if (b[7:6] == CONT_TAG) begin
                partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                conts_seen = conts_seen + 2'd1;
                if (conts_seen >= conts_needed) begin
                    add_cp(partial_cp, 1'b0);
                    partial_cp = '0;
                    conts_needed = EXP_NONE;
                    conts_seen = 2'd0;
                end
            end else begin
                flush_sequence();
                start_byte(b);
            end
        end else begin
            start_byte(b);
        end
        if (fin && conts_needed != EXP_NONE)
            flush_sequence();
        if (burst_n > 0) begin
            r = burst[burst_n-1];
            r.run_last = 1'b1;
            r.text_last = fin;
            burst[burst_n-1] = r;
        end
        for (int i = 0; i < burst_n; i++)
            expected_cps = {expected_cps, burst[i]};
    endtask

    // Sender gap: none during the receiver hold-off and in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (hold_left > 0 || (bytes_sent / 40) % 3 == 0)
            return 0;
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if ((results_seen / 50) % 3 == 1)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        pending_bytes = {pending_bytes, {fin, b}};
    endtask

    task automatic queue_random_fin(input logic [7:0] b);
        queue_byte(b, $urandom_range(0, 15) == 0);
    endtask

    // Record each transfer on the input side and predict its results
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            decode_byte(s_tdata, s_tlast);
            bytes_sent++;
            offering = 1'b0;
            gap_left = pick_gap();
        end
    end

    // Drive the input side: hold an offered byte, else idle or present the next one
    always @(negedge aclk) begin
        if (aresetn && !offering) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_bytes.size() > 0) begin
                {s_tlast, s_tdata} <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                offering = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drive the receiver: one long hold-off once, otherwise random stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_stall();
            end
        end
    end

    // Check each output transfer against the oldest prediction
    always @(posedge aclk) begin
        cp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_cps.size() == 0) begin
                $display("%0t: unexpected result, expected none actual cp %h",
                         $time, m_tdata);
                error_cnt++;
            end else begin
                want = expected_cps.pop_front();
                if (m_tdata !== {3'd0, want.cp}) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, {3'd0, want.cp}, m_tdata);
                    error_cnt++;
                end
                if (m_tuser[0] !== want.err) begin
                    $display("%0t: decode_error expected %b actual %b",
                             $time, want.err, m_tuser[0]);
                    error_cnt++;
                end
                if (m_tuser[1] !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, m_tuser[1]);
                    error_cnt++;
                end
                if (m_tlast !== want.text_last) begin
                    $display("%0t: text_last expected %b actual %b",
                             $time, want.text_last, m_tlast);
                    error_cnt++;
                end
            end
        end
    end

    // Abandon a hung run
    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("utf8_stream_decoder: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          kind;
        int          n_conts;
        int          n_sent_conts;
        logic [31:0] pay;
        logic [7:0]  lead;
        logic [7:0]  b;
        logic [8:0]  tail;

        // Directed: ASCII extremes including the zero byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // Well-formed two, three and four byte forms
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b0);
        // Largest point the four byte form carries
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        // Stray continuation and invalid high bytes
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hF8, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Broken sequence: four results from the failing byte, which also ends the text
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h41, 1'b1);
        // Text ending inside a sequence, and on a lone lead
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        queue_byte(8'hC0, 1'b1);

        // Random: mostly well-formed sequences, some broken ones and noise
        while (pending_bytes.size() < TOTAL_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                queue_random_fin(8'($urandom_range(0, 127)));
            end else if (kind < 88) begin
                pay = $urandom;
                n_conts = $urandom_range(1, 3);
                case (n_conts)
                    1: lead = {LEAD2_TAG, pay[4:0]};
                    2: lead = {LEAD3_TAG, pay[3:0]};
                    default: lead = {LEAD4_TAG, pay[2:0]};
                endcase
                n_sent_conts = (kind < 75) ? n_conts : $urandom_range(0, n_conts - 1);
                queue_random_fin(lead);
                for (int i = 0; i < n_sent_conts; i++) begin
                    pay = $urandom;
                    queue_random_fin({CONT_TAG, pay[5:0]});
                end
                if (kind >= 75) begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b[7:6] == CONT_TAG);
                    queue_random_fin(b);
                end
            end else begin
                queue_random_fin(8'($urandom_range(0, 255)));
            end
        end
        // Close the text on the final byte
        tail = pending_bytes.pop_back();
        tail[8] = 1'b1;
        pending_bytes = {pending_bytes, tail};

        // Hold reset, release on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every byte to be taken and every result to arrive
        while (pending_bytes.size() > 0 || offering || expected_cps.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_cnt == 0)
            $display("utf8_stream_decoder: match");
        else
            $display("utf8_stream_decoder: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_burst.sv
rtl/utf8_stream_decoder.sv
verif/tb_top.sv
